// File: rtl/core/i2p_pkg.sv
// Shared types and constants for the infix-to-postfix converter.
// Used by i2p_cell, infix_to_postfix_converter_core and the sim files; no dependencies.
package i2p_pkg;

  localparam int DEF_STACK_DEPTH = 32;

  typedef enum logic [2:0] {
    ACT_OPERAND  = 3'd0,
    ACT_OPEN     = 3'd1,
    ACT_CLOSE    = 3'd2,
    ACT_PUSHONLY = 3'd3,
    ACT_BINARY   = 3'd4,
    ACT_END      = 3'd5
  } i2p_action_t;

  typedef enum logic [2:0] {
    OK_OPERAND  = 3'd0,
    OK_PUSHONLY = 3'd1,
    OK_BINARY   = 3'd2,
    OK_PAREN    = 3'd3,
    OK_ERROR    = 3'd4
  } i2p_out_kind_t;

  typedef enum logic [1:0] {
    EK_PAREN    = 2'd0,
    EK_PUSHONLY = 2'd1,
    EK_BINARY   = 2'd2
  } i2p_ent_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_OPEN    = 2'd1,
    ERR_STACK_FULL = 2'd2
  } i2p_err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_BIN,
    S_END
  } i2p_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] code;
    logic [3:0] prec;
  } i2p_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } i2p_ctl_t;

  function automatic logic [2:0] ent_to_out_kind(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      EK_PAREN:    r = OK_PAREN;
      EK_PUSHONLY: r = OK_PUSHONLY;
      default:     r = OK_BINARY;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/i2p_cell.sv
// One stack cell of the operator stack chain: holds one entry.
// Shifts toward the bottom on push and toward the top on pop. Uses i2p_pkg.
module i2p_cell
  import i2p_pkg::*;
(
  input  logic       clk,
  input  i2p_ctl_t   ctl,
  input  i2p_entry_t above_i,
  input  i2p_entry_t below_i,
  output i2p_entry_t ent_o
);

  i2p_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_r <= above_i;
    end else if (ctl.pop) begin
      ent_r <= below_i;
    end
  end

  assign ent_o = ent_r;

endmodule

// File: rtl/core/infix_to_postfix_converter_core.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on i2p_pkg and i2p_cell (chain of stack cells).
//
// Usage:
//   Input channel in_*: one infix token per item. in_tuser carries the
//   action, in_tdata the token code, precedence and operand payload.
//   Output channel out_*: postfix items. out_tuser carries kind and error
//   code, out_tlast marks the final item caused by one input item.
//   Operand, open paren and push-only tokens are handled as they are accepted.
//   Close paren, binary operator and end tokens are accepted first, then pop
//   stack entries one at a time; a close paren then drops its open paren and
//   a binary operator then pushes itself.
//   Each pop moves the whole cell chain up one place, so the pop loop sets the
//   rate: one entry per cycle while the output register is free. Results are
//   registered in a single output register.
//   A stalled receiver holds the output register; the pop loop waits and
//   in_tready stays low until the register frees.
//   Reset (rst_n low, synchronous) empties the stack and drops any pending
//   output item; stack cell contents are not cleared.
module infix_to_postfix_converter_core
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // token_code[4:0], precedence[8:5], payload[72:9], zeros
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_code[4:0], out_precedence[8:5], out_payload[72:9], zeros
  output logic [4:0]  out_tuser,  // out_kind[2:0], error_code[4:3]
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  i2p_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [3:0] bprec_r, bprec_nxt;
  logic [4:0] bcode_r, bcode_nxt;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [4:0]  out_code_r;
  logic [3:0]  out_prec_r;
  logic [63:0] out_payload_r;
  logic [1:0]  out_err_r;
  logic        out_last_r;

  logic        emit;
  logic [2:0]  e_kind;
  logic [4:0]  e_code;
  logic [3:0]  e_prec;
  logic [63:0] e_payload;
  logic [1:0]  e_err;
  logic        e_last;

  i2p_ctl_t   ctl;
  i2p_entry_t new_ent;
  i2p_entry_t ent [STACK_DEPTH];
  i2p_entry_t top_e, nxt_e;

  logic        in_fire, slot_free, full;
  logic [2:0]  in_action;
  logic [4:0]  in_code;
  logic [3:0]  in_prec;
  logic [63:0] in_payload;

  assign in_action  = in_tuser;
  assign in_code    = in_tdata[4:0];
  assign in_prec    = in_tdata[8:5];
  assign in_payload = in_tdata[72:9];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (count_r == FULL_CNT);
  assign top_e     = ent[0];
  assign nxt_e     = ent[1];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    i2p_entry_t above_w, below_w;
    if (g == 0) begin : g_top
      assign above_w = new_ent;
    end else begin : g_mid
      assign above_w = ent[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below_w = '0;
    end else begin : g_up
      assign below_w = ent[g+1];
    end
    i2p_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .above_i (above_w),
      .below_i (below_w),
      .ent_o   (ent[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pcnt_nxt  = pcnt_r;
    bprec_nxt = bprec_r;
    bcode_nxt = bcode_r;
    ctl       = '0;
    new_ent   = '0;
    emit      = 1'b0;
    e_kind    = OK_ERROR;
    e_code    = '0;
    e_prec    = '0;
    e_payload = '0;
    e_err     = ERR_NONE;
    e_last    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_OPERAND: begin
              emit      = 1'b1;
              e_kind    = OK_OPERAND;
              e_code    = in_code;
              e_payload = in_payload;
              e_last    = 1'b1;
            end
            ACT_OPEN, ACT_PUSHONLY: begin
              if (full) begin
                emit   = 1'b1;
                e_err  = ERR_STACK_FULL;
                e_last = 1'b1;
              end else begin
                ctl.push     = 1'b1;
                new_ent.kind = (in_action == ACT_OPEN) ? EK_PAREN : EK_PUSHONLY;
                new_ent.code = in_code;
                new_ent.prec = in_prec;
                count_nxt    = count_r + ONE_CNT;
                if (in_action == ACT_OPEN) begin
                  pcnt_nxt = pcnt_r + ONE_CNT;
                end
              end
            end
            ACT_CLOSE: begin
              if (pcnt_r == '0) begin
                emit   = 1'b1;
                e_err  = ERR_NO_OPEN;
                e_last = 1'b1;
              end else begin
                state_nxt = S_CLOSE;
              end
            end
            ACT_BINARY: begin
              bprec_nxt = in_prec;
              bcode_nxt = in_code;
              state_nxt = S_BIN;
            end
            ACT_END: begin
              if (count_r != '0) begin
                state_nxt = S_END;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLOSE: begin
        if (top_e.kind == EK_PAREN) begin
          ctl.pop   = 1'b1;
          count_nxt = count_r - ONE_CNT;
          pcnt_nxt  = pcnt_r - ONE_CNT;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          e_kind    = ent_to_out_kind(top_e.kind);
          e_code    = top_e.code;
          e_prec    = top_e.prec;
          e_last    = (nxt_e.kind == EK_PAREN);
          ctl.pop   = 1'b1;
          count_nxt = count_r - ONE_CNT;
        end
      end
      S_BIN: begin
        if ((count_r != '0) && (top_e.prec >= bprec_r)) begin
          if (slot_free) begin
            emit      = 1'b1;
            e_kind    = ent_to_out_kind(top_e.kind);
            e_code    = top_e.code;
            e_prec    = top_e.prec;
            e_last    = (count_r == ONE_CNT) || (nxt_e.prec < bprec_r);
            ctl.pop   = 1'b1;
            count_nxt = count_r - ONE_CNT;
            if (top_e.kind == EK_PAREN) begin
              pcnt_nxt = pcnt_r - ONE_CNT;
            end
          end
        end else if (full) begin
          if (slot_free) begin
            emit      = 1'b1;
            e_err     = ERR_STACK_FULL;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl.push     = 1'b1;
          new_ent.kind = EK_BINARY;
          new_ent.code = bcode_r;
          new_ent.prec = bprec_r;
          count_nxt    = count_r + ONE_CNT;
          state_nxt    = S_IDLE;
        end
      end
      S_END: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = ent_to_out_kind(top_e.kind);
          e_code    = top_e.code;
          e_prec    = top_e.prec;
          e_last    = (count_r == ONE_CNT);
          ctl.pop   = 1'b1;
          count_nxt = count_r - ONE_CNT;
          if (top_e.kind == EK_PAREN) begin
            pcnt_nxt = pcnt_r - ONE_CNT;
          end
          if (count_r == ONE_CNT) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pcnt_r  <= pcnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bprec_r <= bprec_nxt;
    bcode_r <= bcode_nxt;
    if (emit) begin
      out_kind_r    <= e_kind;
      out_code_r    <= e_code;
      out_prec_r    <= e_prec;
      out_payload_r <= e_payload;
      out_err_r     <= e_err;
      out_last_r    <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_payload_r, out_prec_r, out_code_r};
  assign out_tuser  = {out_err_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

// File: sim/postfix_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for infix_to_postfix_converter_core: predicts postfix items
// with its own operator stack and compares them against the output stream.
// Depends on i2p_pkg.
module postfix_stream_checker
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,   // token_code[4:0], precedence[8:5], payload[72:9], zeros
  input  logic [2:0]  in_tuser,   // action[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,  // out_code[4:0], out_precedence[8:5], out_payload[72:9], zeros
  input  logic [4:0]  out_tuser,  // out_kind[2:0], error_code[4:3]
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [3:0]  prec;
    logic [63:0] payload;
    logic [1:0]  err;
    logic        last;
  } postfix_item_t;

  i2p_entry_t    op_stack [STACK_DEPTH];
  int            op_depth;
  postfix_item_t postfix_due [$];
  postfix_item_t step_items [$];

  function automatic void emit_item(logic [2:0] kind, logic [4:0] code, logic [3:0] prec,
                                    logic [63:0] payload, logic [1:0] err);
    postfix_item_t it;
    it.kind = kind;
    it.code = code;
    it.prec = prec;
    it.payload = payload;
    it.err = err;
    it.last = 1'b0;
    step_items.push_back(it);
  endfunction

  function automatic void pop_operator();
    i2p_entry_t top;
    logic [2:0] k;
    top = op_stack[op_depth-1];
    case (top.kind)
      EK_PAREN:    k = OK_PAREN;
      EK_PUSHONLY: k = OK_PUSHONLY;
      default:     k = OK_BINARY;
    endcase
    emit_item(k, top.code, top.prec, '0, ERR_NONE);
    op_depth--;
  endfunction

  function automatic void push_operator(logic [1:0] kind, logic [4:0] code, logic [3:0] prec);
    if (op_depth >= STACK_DEPTH) begin
      emit_item(OK_ERROR, '0, '0, '0, ERR_STACK_FULL);
    end else begin
      op_stack[op_depth].kind = kind;
      op_stack[op_depth].code = code;
      op_stack[op_depth].prec = prec;
      op_depth++;
    end
  endfunction

  function automatic void predict_postfix(logic [2:0] act, logic [4:0] code, logic [3:0] prec,
                                          logic [63:0] payload);
    bit found;
    found = 1'b0;
    step_items.delete();
    case (act)
      ACT_OPERAND:  emit_item(OK_OPERAND, code, '0, payload, ERR_NONE);
      ACT_OPEN:     push_operator(EK_PAREN, code, prec);
      ACT_PUSHONLY: push_operator(EK_PUSHONLY, code, prec);
      ACT_CLOSE: begin
        for (int i = 0; i < op_depth; i++)
          if (op_stack[i].kind == EK_PAREN) found = 1'b1;
        if (!found) begin
          emit_item(OK_ERROR, '0, '0, '0, ERR_NO_OPEN);
        end else begin
          while (op_stack[op_depth-1].kind != EK_PAREN) pop_operator();
          op_depth--;
        end
      end
      ACT_BINARY: begin
        while (op_depth > 0 && op_stack[op_depth-1].prec >= prec) pop_operator();
        push_operator(EK_BINARY, code, prec);
      end
      ACT_END: begin
        while (op_depth > 0) pop_operator();
      end
      default: ;
    endcase
    if (step_items.size() > 0) step_items[step_items.size()-1].last = 1'b1;
    foreach (step_items[i]) postfix_due.push_back(step_items[i]);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    postfix_item_t want;
    if (!rst_n) begin
      op_depth = 0;
      postfix_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_postfix(in_tuser, in_tdata[4:0], in_tdata[8:5], in_tdata[72:9]);
      if (out_tvalid && out_tready) begin
        if (postfix_due.size() == 0) begin
          $error("unexpected output item: kind %0d code %0d error %0d",
                 out_tuser[2:0], out_tdata[4:0], out_tuser[4:3]);
          fail_count++;
        end else begin
          want = postfix_due.pop_front();
          check_field("out_kind", 64'(want.kind), 64'(out_tuser[2:0]));
          check_field("out_code", 64'(want.code), 64'(out_tdata[4:0]));
          check_field("out_precedence", 64'(want.prec), 64'(out_tdata[8:5]));
          check_field("out_payload", want.payload, out_tdata[72:9]);
          check_field("error_code", 64'(want.err), 64'(out_tuser[4:3]));
          check_field("last", 64'(want.last), 64'(out_tlast));
        end
      end
    end
    pending = postfix_due.size();
  end

endmodule

// File: sim/infix_to_postfix_converter_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for infix_to_postfix_converter_core: drives directed and random
// token streams with random idling on both sides and gives the verdict.
// Depends on i2p_pkg, the core and postfix_stream_checker.
module infix_to_postfix_converter_core_tb;
  import i2p_pkg::*;

  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int RANDOM_TOKENS = 135;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          tokens_sent;
  bit          idle_on;

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  postfix_stream_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_token(logic [2:0] act, logic [4:0] code, logic [3:0] prec,
                            logic [63:0] payload);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {7'b0, payload, prec, code};
    do @(posedge clk); while (!in_tready);
    if (act <= ACT_END) tokens_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // fill the stack to around its depth (it may overflow), maybe add a binary and a close, then flush
  task automatic fill_stack();
    int n;
    n = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 3);
    repeat (n)
      send_token($urandom_range(0, 1) ? ACT_OPEN : ACT_PUSHONLY, 5'($urandom_range(0, 31)),
                 4'($urandom_range(0, 15)), rand_word());
    if ($urandom_range(0, 1))
      send_token(ACT_BINARY, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                 rand_word());
    if ($urandom_range(0, 1))
      send_token(ACT_CLOSE, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                 rand_word());
    send_token(ACT_END, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)), rand_word());
  endtask

  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  initial begin
    int base;
    int r;
    int open_depth;
    bit want_operand;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    rst_n = 1'b0;
    idle_on = 1'b1;
    tokens_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_token(ACT_OPERAND, 5'd31, 4'd15, '1);
    send_token(ACT_OPERAND, 5'd0, 4'd0, '0);
    send_token(ACT_CLOSE, 5'd7, 4'd0, rand_word());
    send_token(ACT_END, 5'd0, 4'd0, '0);
    send_token(3'd6, 5'd31, 4'd15, '1);
    send_token(3'd7, 5'd12, 4'd3, rand_word());
    send_token(ACT_OPEN, 5'd1, 4'd0, '0);
    send_token(ACT_OPERAND, 5'd9, 4'd0, rand_word());
    send_token(ACT_BINARY, 5'd2, 4'd5, '0);
    send_token(ACT_OPERAND, 5'd9, 4'd0, rand_word());
    send_token(ACT_CLOSE, 5'd1, 4'd0, '0);
    send_token(ACT_PUSHONLY, 5'd3, 4'd15, '0);
    send_token(ACT_OPERAND, 5'd10, 4'd0, rand_word());
    send_token(ACT_BINARY, 5'd4, 4'd15, '0);
    send_token(ACT_OPEN, 5'd1, 4'd3, '0);
    send_token(ACT_OPERAND, 5'd11, 4'd0, rand_word());
    send_token(ACT_BINARY, 5'd5, 4'd2, '0);
    send_token(ACT_OPERAND, 5'd12, 4'd0, rand_word());
    send_token(ACT_OPEN, 5'd31, 4'd0, rand_word());
    send_token(ACT_CLOSE, 5'd1, 4'd0, '0);
    send_token(ACT_CLOSE, 5'd1, 4'd0, '0);
    send_token(ACT_BINARY, 5'd0, 4'd0, '0);
    send_token(ACT_OPEN, 5'd1, 4'd15, '0);
    send_token(ACT_END, 5'd31, 4'd15, '1);
    drain_results();

    base = tokens_sent;
    open_depth = 0;
    want_operand = 1'b1;
    while (tokens_sent - base < RANDOM_TOKENS) begin
      idle_on = ((tokens_sent - base) / 30) % 3 != 2;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        fill_stack();
        open_depth = 0;
        want_operand = 1'b1;
      end else if (r < 12) begin
        send_token(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                   4'($urandom_range(0, 15)), rand_word());
      end else if (want_operand) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_token(ACT_OPERAND, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     rand_word());
          want_operand = 1'b0;
        end else if (r < 85) begin
          send_token(ACT_OPEN, 5'($urandom_range(0, 31)),
                     $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'd0,
                     rand_word());
          open_depth++;
        end else begin
          send_token(ACT_PUSHONLY, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     rand_word());
        end
      end else begin
        r = $urandom_range(0, 99);
        if (open_depth > 0 && r < 25) begin
          send_token(ACT_CLOSE, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     rand_word());
          open_depth--;
        end else if (r < 40) begin
          send_token(ACT_END, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     rand_word());
          open_depth = 0;
          want_operand = 1'b1;
          if ($urandom_range(0, 3) == 0) drain_results();
        end else begin
          send_token(ACT_BINARY, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     rand_word());
          want_operand = 1'b1;
        end
      end
    end
    send_token(ACT_END, 5'd0, 4'd0, '0);

    drain_results();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
